// ===== hw/rtl/ppd_pkg.sv =====
`timescale 1ns / 1ps

package ppd_pkg;

   // Header classes taken from the top three bits of a header byte.
   localparam logic [2:0] CLS_REL = 3'b100;
   localparam logic [2:0] CLS_ABS = 3'b110;
   localparam logic [2:0] CLS_POR = 3'b101;

   localparam logic [2:0] LEN_REL = 3'd3;
   localparam logic [2:0] LEN_ABS = 3'd5;
   localparam logic [2:0] LEN_POR = 3'd4;

   localparam logic [1:0] KIND_REL = 2'd0;
   localparam logic [1:0] KIND_ABS = 2'd1;
   localparam logic [1:0] KIND_POR = 2'd2;

   localparam int unsigned HEAD_BYTES = 5;
   localparam logic [2:0] MAX_RESULTS = 3'd6;
   localparam logic [6:0] ERR_LIMIT = 7'd31;
   localparam logic signed [12:0] Y_FLIP = 13'sd1023;

   typedef logic [HEAD_BYTES-1:0][7:0] ppd_head_type;

   typedef struct packed {
      logic shift;
      logic load;
   } ppd_cell_ctl_type;

   typedef struct packed {
      logic [1:0]          packet_kind;
      logic [3:0]          buttons;
      logic signed [12:0]  value_x;
      logic signed [12:0]  value_y;
      logic [3:0]          revision;
      logic [2:0]          country_code;
      logic [3:0]          device_kind;
      logic [6:0]          selftest_error;
      logic                buttons_valid;
   } ppd_result_type;

endpackage

// ===== hw/rtl/ppd_cell.sv =====
`timescale 1ns / 1ps

module ppd_cell
   import ppd_pkg::*;
(
   input  logic             clock,
   input  ppd_cell_ctl_type ctl,
   input  logic [7:0]       load_byte,
   input  logic [7:0]       next_byte,
   output logic [7:0]       cell_byte
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   // A fresh byte wins over the shift, so the tail cell of a full chain takes it.
   always_comb begin
      priority if (ctl.load) begin
         byte_in = load_byte;
      end else if (ctl.shift) begin
         byte_in = next_byte;
      end else begin
         byte_in = byte_ff;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
   end

   assign cell_byte = byte_ff;

endmodule

// ===== hw/rtl/ppd_decoder.sv =====
`timescale 1ns / 1ps

module ppd_decoder
   import ppd_pkg::*;
(
   input  ppd_head_type   head,
   output ppd_result_type result,
   output logic [2:0]     pkt_len,
   output logic           known
);

   logic signed [12:0] mag_x;
   logic signed [12:0] mag_y;
   logic [11:0]        raw_y;
   logic [6:0]         err;
   logic               err_ok;

   assign mag_x  = signed'({6'd0, head[1][6:0]});
   assign mag_y  = signed'({6'd0, head[2][6:0]});
   assign raw_y  = {head[4][5:0], head[3][5:0]};
   assign err    = head[2][6:0];
   assign err_ok = (err <= ERR_LIMIT);

   always_comb begin
      result  = '0;
      pkt_len = '0;
      known   = 1'b0;
      unique case (head[0][7:5])
         CLS_REL: begin
            known                = 1'b1;
            pkt_len              = LEN_REL;
            result.packet_kind   = KIND_REL;
            result.buttons       = {1'b0, head[0][0], head[0][1], head[0][2]};
            // Header bit 4 set means positive dx, bit 3 set means negative dy.
            result.value_x       = head[0][4] ? mag_x : -mag_x;
            result.value_y       = head[0][3] ? -mag_y : mag_y;
            result.buttons_valid = 1'b1;
         end
         CLS_ABS: begin
            known                = 1'b1;
            pkt_len              = LEN_ABS;
            result.packet_kind   = KIND_ABS;
            result.buttons       = {head[0][4], head[0][3], head[0][2], head[0][1]};
            result.value_x       = signed'({1'b0, head[2][5:0], head[1][5:0]});
            result.value_y       = Y_FLIP - signed'({1'b0, raw_y});
            result.buttons_valid = 1'b1;
         end
         CLS_POR: begin
            known                 = 1'b1;
            pkt_len               = LEN_POR;
            result.packet_kind    = KIND_POR;
            result.buttons        = err_ok ? {1'b0, head[0][0], head[0][1], head[0][2]}
                                           : 4'd0;
            result.revision       = head[0][3:0];
            result.country_code   = head[1][6:4];
            result.device_kind    = head[1][3:0];
            result.selftest_error = err;
            result.buttons_valid  = err_ok;
         end
         default: begin
            known = 1'b0;
         end
      endcase
   end

endmodule

// ===== hw/rtl/pointer_packet_deframer.sv =====
`timescale 1ns / 1ps

// Deframes packets from a serial pointing device. Each received byte is queued in a
// chain of STORE_BYTES byte cells (the oldest byte falls out when the chain is full),
// then the chain is parsed from its head: loose data bytes and broken packets are
// shifted out, and every complete relative, tablet or power-on packet is decoded into
// one result transfer, at most six per byte, the final one marked by rsp_tlast. The
// chain moves at most one position per cycle: the byte is enqueued, each discarded
// byte is shifted out, each decoded packet is taken in a decode step and then
// shifted out byte by byte, and at the end the parse closes and hands over the last
// result. A new byte is taken only once the previous one is fully parsed; the last
// result may still wait in the output register meanwhile.
module pointer_packet_deframer
   import ppd_pkg::*;
#(
   parameter int unsigned STORE_BYTES = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [3:0] buttons, [16:4] value_x, [29:17] value_y,
                                    // [33:30] revision, [36:34] country_code,
                                    // [40:37] device_kind, [47:41] selftest_error,
                                    // [48] buttons_valid, [55:49] zero
   output logic [1:0]  rsp_tuser,   // [1:0] packet_kind
   output logic        rsp_tlast    // last_of_run
);

   localparam int unsigned FW = $clog2(STORE_BYTES + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_PARSE = 4'b0010,
      ST_DROP  = 4'b0100,
      ST_FLUSH = 4'b1000
   } state_type;

   state_type      state_ff, state_in;
   logic [FW-1:0]  fill_ff, fill_in;
   logic [2:0]     count_ff, count_in;
   logic [2:0]     drop_ff, drop_in;
   logic           pend_valid_ff, pend_valid_in;
   ppd_result_type pend_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   ppd_result_type rsp_data_ff;
   logic           rsp_last_ff;

   logic [7:0]     cell_byte [STORE_BYTES];
   ppd_head_type   head;
   ppd_result_type decoded;
   logic [2:0]     pkt_len;
   logic           known;

   logic           accept, full, shift_all, slot_free;
   logic           take_pkt, out_load, out_last, stray;

   assign accept    = req_tvalid && req_tready;
   assign full      = (fill_ff == FW'(STORE_BYTES));
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // Byte cells: cell 0 holds the oldest byte; a shift moves everything one place on.
   for (genvar i = 0; i < STORE_BYTES; i++) begin : g_cell
      ppd_cell_ctl_type ctl;
      logic [7:0]       next_byte;
      if (i == STORE_BYTES - 1) begin : g_tail
         assign next_byte = 8'h00;
         assign ctl.load  = accept;
      end else begin : g_body
         assign next_byte = cell_byte[i+1];
         assign ctl.load  = accept && !full && (fill_ff == FW'(i));
      end
      assign ctl.shift = shift_all;
      ppd_cell u_cell (
         .clock     (clock),
         .ctl       (ctl),
         .load_byte (req_tdata),
         .next_byte (next_byte),
         .cell_byte (cell_byte[i])
      );
   end

   for (genvar h = 0; h < HEAD_BYTES; h++) begin : g_head
      assign head[h] = cell_byte[h];
   end

   ppd_decoder u_decoder (
      .head    (head),
      .result  (decoded),
      .pkt_len (pkt_len),
      .known   (known)
   );

   // A header inside the packet: dropping the leading header alone is enough, the
   // data bytes behind it then go one by one as loose bytes.
   always_comb begin
      stray = head[1][7] || head[2][7];
      if (pkt_len >= LEN_POR) begin
         stray = stray || head[3][7];
      end
      if (pkt_len == LEN_ABS) begin
         stray = stray || head[4][7];
      end
   end

   always_comb begin
      state_in      = state_ff;
      fill_in       = fill_ff;
      count_in      = count_ff;
      drop_in       = drop_ff;
      pend_valid_in = pend_valid_ff;
      shift_all     = 1'b0;
      take_pkt      = 1'b0;
      out_load      = 1'b0;
      out_last      = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               count_in = '0;
               state_in = ST_PARSE;
               if (full) begin
                  shift_all = 1'b1;
               end else begin
                  fill_in = fill_ff + FW'(1);
               end
            end
         end
         ST_PARSE: begin
            priority if (count_ff == MAX_RESULTS || fill_ff == '0) begin
               state_in = ST_FLUSH;
            end else if (!head[0][7]) begin
               shift_all = 1'b1;
               fill_in   = fill_ff - FW'(1);
            end else if (!known || fill_ff < FW'(pkt_len)) begin
               state_in = ST_FLUSH;
            end else if (stray) begin
               shift_all = 1'b1;
               fill_in   = fill_ff - FW'(1);
            end else if (!pend_valid_ff || slot_free) begin
               take_pkt      = 1'b1;
               out_load      = pend_valid_ff;
               pend_valid_in = 1'b1;
               count_in      = count_ff + 3'd1;
               drop_in       = pkt_len;
               state_in      = ST_DROP;
            end
         end
         ST_DROP: begin
            shift_all = 1'b1;
            fill_in   = fill_ff - FW'(1);
            drop_in   = drop_ff - 3'd1;
            if (drop_ff == 3'd1) begin
               state_in = ST_PARSE;
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (slot_free) begin
               out_load      = 1'b1;
               out_last      = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         fill_ff       <= '0;
         count_ff      <= '0;
         drop_ff       <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_ff       <= fill_in;
         count_ff      <= count_in;
         drop_ff       <= drop_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take_pkt) begin
         pend_ff <= decoded;
      end
      if (out_load) begin
         rsp_data_ff <= pend_ff;
         rsp_last_ff <= out_last;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_data_ff.packet_kind;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {7'd0,
                        rsp_data_ff.buttons_valid,
                        rsp_data_ff.selftest_error,
                        rsp_data_ff.device_kind,
                        rsp_data_ff.country_code,
                        rsp_data_ff.revision,
                        rsp_data_ff.value_y,
                        rsp_data_ff.value_x,
                        rsp_data_ff.buttons};

`ifndef ASSERT_OFF
   a_idle_no_pending: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !pend_valid_ff)
      else $error("byte accepted while a decoded packet is still pending");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FW'(STORE_BYTES))
      else $error("fill level beyond chain length");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= MAX_RESULTS)
      else $error("too many packets decoded for one byte");

   a_drop_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DROP) |-> (fill_ff != '0) && (drop_ff != 3'd0))
      else $error("packet removal on an empty chain");
`endif

endmodule

// ===== verif/pointer_packet_deframer_test.sv =====
`timescale 1ns / 1ps

module pointer_packet_deframer_test
   import ppd_pkg::*;
();

   localparam int STORE_DEPTH    = 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 4 * STORE_DEPTH + 40;

   typedef struct packed {
      ppd_result_type fld;
      logic           last;
   } packet_report_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   logic [7:0]        pending_bytes[$];
   packet_report_type expected_packets[$];

   // Shadow of the device byte chain.
   logic [7:0]  rx_store [STORE_DEPTH];
   int unsigned rx_fill = 0;

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;
   int quiet_cycles = 0;
   int mismatches = 0;
   int bytes_accepted = 0;
   int packets_checked = 0;

   pointer_packet_deframer #(.STORE_BYTES(STORE_DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void shift_out(int unsigned n);
      if (n >= rx_fill) begin
         rx_fill = 0;
      end else begin
         for (int i = 0; i < int'(rx_fill - n); i++) rx_store[i] = rx_store[i + n];
         rx_fill -= n;
      end
   endfunction

   // Queues one received byte and predicts the packets it completes, up to MAX_RESULTS.
   function automatic void deframe_byte(logic [7:0] rx);
      int                found;
      int                plen;
      int                stray;
      int                dx;
      int                dy;
      bit                done;
      logic [7:0]        hdr;
      logic [11:0]       ypos;
      logic [6:0]        err;
      packet_report_type pkt;
      found = 0;
      done = 1'b0;
      if (rx_fill >= STORE_DEPTH) shift_out(1);
      rx_store[rx_fill] = rx;
      rx_fill++;
      while (!done && found < int'(MAX_RESULTS)) begin
         while (rx_fill > 0 && !rx_store[0][7]) shift_out(1);
         if (rx_fill == 0) begin
            done = 1'b1;
         end else begin
            hdr = rx_store[0];
            case (hdr[7:5])
               CLS_REL: plen = LEN_REL;
               CLS_ABS: plen = LEN_ABS;
               CLS_POR: plen = LEN_POR;
               default: plen = 0;
            endcase
            if (plen == 0 || int'(rx_fill) < plen) begin
               done = 1'b1;
            end else begin
               stray = 0;
               for (int i = plen - 1; i >= 1; i--) if (rx_store[i][7]) stray = i;
               if (stray > 0) begin
                  shift_out(stray);
               end else begin
                  pkt = '0;
                  pkt.fld.buttons_valid = 1'b1;
                  if (hdr[7:5] == CLS_REL) begin
                     dx = int'(rx_store[1][6:0]);
                     dy = int'(rx_store[2][6:0]);
                     if (!hdr[4]) dx = -dx;
                     if (hdr[3]) dy = -dy;
                     pkt.fld.packet_kind = KIND_REL;
                     pkt.fld.buttons = {1'b0, hdr[0], hdr[1], hdr[2]};
                     pkt.fld.value_x = dx[12:0];
                     pkt.fld.value_y = dy[12:0];
                  end else if (hdr[7:5] == CLS_ABS) begin
                     ypos = {rx_store[4][5:0], rx_store[3][5:0]};
                     dy = int'(Y_FLIP) - int'(ypos);
                     pkt.fld.packet_kind = KIND_ABS;
                     pkt.fld.buttons = hdr[4:1];
                     pkt.fld.value_x = {1'b0, rx_store[2][5:0], rx_store[1][5:0]};
                     pkt.fld.value_y = dy[12:0];
                  end else begin
                     err = rx_store[2][6:0];
                     pkt.fld.packet_kind = KIND_POR;
                     pkt.fld.buttons_valid = (err <= ERR_LIMIT);
                     pkt.fld.buttons = (err <= ERR_LIMIT) ?
                                       {1'b0, hdr[0], hdr[1], hdr[2]} : 4'd0;
                     pkt.fld.revision = hdr[3:0];
                     pkt.fld.country_code = rx_store[1][6:4];
                     pkt.fld.device_kind = rx_store[1][3:0];
                     pkt.fld.selftest_error = err;
                  end
                  expected_packets.push_back(pkt);
                  shift_out(plen);
                  found++;
               end
            end
         end
      end
      if (found > 0) expected_packets[$].last = 1'b1;
   endfunction

   task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
      if (want !== got) begin
         $display("%0t: %s expected %0d, actual %0d", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic check_packet();
      packet_report_type want;
      if (expected_packets.size() == 0) begin
         $display("%0t: result transfer with none expected, expected nothing, actual tdata %h",
                  $time, rsp_tdata);
         mismatches++;
      end else begin
         want = expected_packets.pop_front();
         packets_checked++;
         check_field("packet_kind", want.fld.packet_kind, rsp_tuser);
         check_field("buttons", want.fld.buttons, rsp_tdata[3:0]);
         check_field("value_x", $signed(want.fld.value_x), $signed(rsp_tdata[16:4]));
         check_field("value_y", $signed(want.fld.value_y), $signed(rsp_tdata[29:17]));
         check_field("revision", want.fld.revision, rsp_tdata[33:30]);
         check_field("country_code", want.fld.country_code, rsp_tdata[36:34]);
         check_field("device_kind", want.fld.device_kind, rsp_tdata[40:37]);
         check_field("selftest_error", want.fld.selftest_error, rsp_tdata[47:41]);
         check_field("buttons_valid", want.fld.buttons_valid, rsp_tdata[48]);
         check_field("tdata padding", 0, rsp_tdata[55:49]);
         check_field("last_of_run", want.last, rsp_tlast);
      end
   endtask

   // Mostly well-formed packets with random content, mixed with truncated packets,
   // loose data bytes, arbitrary bytes and unknown headers that block the chain.
   task automatic add_random_traffic(int target);
      int         made;
      int         sel;
      int         plen;
      int         keep;
      logic [7:0] hdr;
      made = 0;
      while (made < target) begin
         sel = $urandom_range(99);
         case ($urandom_range(2))
            0: begin
               hdr = {CLS_REL, 5'($urandom)};
               plen = LEN_REL;
            end
            1: begin
               hdr = {CLS_ABS, 5'($urandom)};
               plen = LEN_ABS;
            end
            default: begin
               hdr = {CLS_POR, 5'($urandom)};
               plen = LEN_POR;
            end
         endcase
         if (sel < 70) begin
            pending_bytes.push_back(hdr);
            for (int i = 1; i < plen; i++) pending_bytes.push_back({1'b0, 7'($urandom)});
            made += plen;
         end else if (sel < 80) begin
            keep = $urandom_range(plen - 2) + 1;
            pending_bytes.push_back(hdr);
            for (int i = 1; i < keep; i++) pending_bytes.push_back({1'b0, 7'($urandom)});
            made += keep;
         end else if (sel < 90) begin
            pending_bytes.push_back({1'b0, 7'($urandom)});
         end else if (sel < 96) begin
            pending_bytes.push_back(8'($urandom));
            made++;
         end else begin
            pending_bytes.push_back({3'b111, 5'($urandom)});
            made++;
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || req_tvalid || expected_packets.size() != 0)
         @(negedge clock);
   endtask

   // Byte sender: a transfer stays offered until it is taken.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            deframe_byte(req_tdata);
            bytes_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tdata <= pending_bytes.pop_front();
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result receiver with random back-pressure and one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_packet();
         if (hold_request && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            rsp_tready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transfer for %0d cycles, %0d packets still outstanding",
                  $time, quiet_cycles, expected_packets.size());
         $display("pointer_packet_deframer: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      send_idle_pct = 33;
      recv_idle_pct = 48;
      // A relative packet broken by a tablet header, the tablet at its corner, a
      // power-on report right at the error limit, then an unknown header that holds
      // the chain until the full-store drop releases four packets on one byte.
      pending_bytes = {8'h80, 8'h01, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00,
                       8'hA5, 8'h24, 8'h1F, 8'h00,
                       8'hE0, 8'h80, 8'h7F, 8'h7F, 8'h9F, 8'h00, 8'h7F,
                       8'hDE, 8'h7F, 8'h7F, 8'h7F, 8'h7F,
                       8'hAF, 8'h7F, 8'h7F, 8'h00, 8'h00};
      add_random_traffic(100);
      wait_drained();

      send_idle_pct = 48;
      recv_idle_pct = 33;
      add_random_traffic(100);
      wait_drained();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      add_random_traffic(100);
      hold_request = 1'b1;
      wait_drained();

      repeat (SETTLE_CYCLES) @(negedge clock);
      $display("Sent %0d bytes and checked %0d decoded packets over three flow-control mixes,",
               bytes_accepted, packets_checked);
      $display("including a long result hold-off with the byte input backed up.");
      if (mismatches == 0) begin
         $display("pointer_packet_deframer: match");
      end else begin
         $display("pointer_packet_deframer: mismatch");
      end
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/ppd_pkg.sv
hw/rtl/ppd_cell.sv
hw/rtl/ppd_decoder.sv
hw/rtl/pointer_packet_deframer.sv
verif/pointer_packet_deframer_test.sv
